@@ rtl/teg_pkg.sv @@
// ----------------------------------------------------------------------------
// teg_pkg
// Shared types and constants for the table-driven envelope generator:
// request and phase codes, datapath operation selects, controller states and
// the command and status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package teg_pkg;

  // field widths
  localparam int REQ_W       = 2;
  localparam int INDEX_W     = 4;
  localparam int DATA_W      = 16;
  localparam int ACT_W       = 3;
  localparam int CFG_W       = 15;
  localparam int PHASE_W     = 4;
  localparam int FINE_W      = 32;
  localparam int REG_IDX_W   = 2;
  localparam int INDEX_RANGE = 1 << INDEX_W;

  // divider widths
  localparam int DIVIDEND_W  = 32;
  localparam int DIVISOR_W   = 16;

  // sustain hold is sustain level / 16 ticks
  localparam int SUS_SHIFT   = 4;

  // release cuts off below this level
  localparam logic signed [DATA_W-1:0] RELEASE_FLOOR = 16'sd100;

  // action flag bit positions
  localparam int ACT_HANG    = 0;
  localparam int ACT_DECAY   = 1;
  localparam int ACT_RELEASE = 2;

  // sentinel delays of a table entry
  localparam logic [DATA_W-1:0] DLY_DISABLE = 16'h0000;
  localparam logic [DATA_W-1:0] DLY_HANG    = 16'hFFFF;
  localparam logic [DATA_W-1:0] DLY_GOTO    = 16'hFFFE;
  localparam logic [DATA_W-1:0] DLY_RESTART = 16'hFFFD;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_POST  = 2'd2,
    REQ_START = 2'd3
  } req_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_INITIAL = 2'd0,
    REG_SUSTAIN = 2'd1,
    REG_STEP    = 2'd2
  } cfg_reg_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_DISABLED   = 4'd0,
    PH_INITIAL    = 4'd1,
    PH_START_LOOP = 4'd2,
    PH_LOOP       = 4'd3,
    PH_FADE       = 4'd4,
    PH_HANG       = 4'd5,
    PH_DECAY      = 4'd6,
    PH_RELEASE    = 4'd7,
    PH_SUSTAIN    = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    EK_DISABLE,
    EK_HANG,
    EK_GOTO,
    EK_RESTART,
    EK_FADE
  } ent_kind_t;

  typedef enum logic [2:0] {
    LVL_KEEP,
    LVL_INITIAL,
    LVL_STEP,
    LVL_SUSTAIN,
    LVL_ZERO,
    LVL_FADE
  } lvl_op_t;

  typedef enum logic [2:0] {
    TCK_KEEP,
    TCK_CLEAR,
    TCK_ENTRY,
    TCK_DEC,
    TCK_SUSTAIN
  } tck_op_t;

  typedef enum logic [1:0] {
    PTR_KEEP,
    PTR_ZERO,
    PTR_INC,
    PTR_GOTO
  } ptr_op_t;

  typedef enum logic [1:0] {
    VEL_KEEP,
    VEL_CLEAR,
    VEL_QUOT
  } vel_op_t;

  typedef enum logic [1:0] {
    FINE_KEEP,
    FINE_LOAD,
    FINE_ADD
  } fine_op_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_RUN,
    C_DECODE,
    C_DIV_GOTO,
    C_DIV_FADE,
    C_FLAGS,
    C_DONE
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic     capture;
    logic     mem_wr;
    logic     mem_rd;
    logic     div_start;
    logic     div_goto;
    lvl_op_t  lvl_op;
    tck_op_t  tck_op;
    ptr_op_t  ptr_op;
    vel_op_t  vel_op;
    fine_op_t fine_op;
    logic     out_load;
    phase_t   phase;
  } teg_cmd_t;

  // datapath to controller
  typedef struct packed {
    req_t             req;
    logic [ACT_W-1:0] action_bits;
    ent_kind_t        ent_kind;
    logic             div_done;
    logic             fade_end;
    logic             sus_end;
    logic             sustain_nz;
    logic             below_sus;
    logic             below_floor;
  } teg_sts_t;

endpackage

@@ rtl/teg_div.sv @@
// ----------------------------------------------------------------------------
// teg_div
// Radix-2 restoring divider, one quotient bit per cycle. Signed operands are
// taken as magnitudes and the quotient sign is restored at the end, so the
// quotient truncates toward zero.
// ----------------------------------------------------------------------------
module teg_div
  import teg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  signed_op,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  den_r, den_nxt;
  logic                  neg_r, neg_nxt;

  logic                  dvd_neg, dvs_neg;
  logic [DIVIDEND_W-1:0] dvd_mag;
  logic [DIVISOR_W-1:0]  dvs_mag;
  logic [DIVISOR_W:0]    rem_sh, rem_diff;
  logic                  fits;

  // operand magnitudes
  always_comb begin
    dvd_neg = signed_op & dividend[DIVIDEND_W-1];
    dvs_neg = signed_op & divisor[DIVISOR_W-1];
    dvd_mag = dvd_neg ? (~dividend + DIVIDEND_W'(1)) : dividend;
    dvs_mag = dvs_neg ? (~divisor + DIVISOR_W'(1)) : divisor;
  end

  // one shift-subtract step
  always_comb begin
    rem_sh   = {rem_r, quo_r[DIVIDEND_W-1]};
    rem_diff = rem_sh - {1'b0, den_r};
    fits     = ~rem_diff[DIVISOR_W];
  end

  // iteration control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dvd_mag;
      rem_nxt  = '0;
      den_nxt  = dvs_mag;
      neg_nxt  = dvd_neg ^ dvs_neg;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      rem_nxt = fits ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + DIVIDEND_W'(1)) : quo_r;

endmodule

@@ rtl/teg_dp.sv @@
// ----------------------------------------------------------------------------
// teg_dp
// Envelope datapath: request capture, configuration registers, the envelope
// table, level and 16.16 fine level, fade velocity, tick counter, table
// pointer, the fade divider, the goto slot fold and the result register.
// ----------------------------------------------------------------------------
module teg_dp
  import teg_pkg::*;
#(
  parameter int ENV_DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [REQ_W-1:0]         in_req_type,
  input  logic [INDEX_W-1:0]       in_entry_index,
  input  logic signed [DATA_W-1:0] in_entry_delay,
  input  logic signed [DATA_W-1:0] in_entry_arg,
  input  logic [ACT_W-1:0]         in_action_bits,
  input  logic                     cfg_we,
  input  logic [REG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  teg_cmd_t                 cmd,
  output teg_sts_t                 sts,
  output logic signed [DATA_W-1:0] out_level,
  output logic [PHASE_W-1:0]       out_phase
);

  localparam int PW = $clog2(ENV_DEPTH);
  localparam logic [PW-1:0]     PTR_LAST = PW'(ENV_DEPTH - 1);
  localparam logic [DATA_W-1:0] DEPTH_W  = DATA_W'(ENV_DEPTH);

  // goto fold: arg * floor(2^GOTO_SH / depth) >> GOTO_SH is low by at most one
  localparam int GOTO_SH = 24;
  localparam int GOTO_PW = DATA_W + GOTO_SH;
  localparam logic [GOTO_SH-1:0] GOTO_MUL = GOTO_SH'((64'd1 << GOTO_SH) / ENV_DEPTH);

  // captured request
  logic [REQ_W-1:0]   req_r;
  logic [INDEX_W-1:0] idx_r;
  logic [DATA_W-1:0]  delay_r;
  logic [DATA_W-1:0]  arg_r;
  logic [ACT_W-1:0]   bits_r;

  // configuration
  logic [CFG_W-1:0] initial_r, sustain_r, step_r;

  // envelope state
  logic [DATA_W-1:0] level_r, level_nxt;
  logic [FINE_W-1:0] fine_r, fine_nxt;
  logic [FINE_W-1:0] vel_r, vel_nxt;
  logic [DATA_W-1:0] ticks_r, ticks_nxt;
  logic [PW-1:0]     ptr_r, ptr_nxt;

  // table memory
  logic [2*DATA_W-1:0] mem [ENV_DEPTH];
  logic [2*DATA_W-1:0] rd_data_r;
  logic [PW-1:0]       idx_tab [INDEX_RANGE];

  // result register
  logic [DATA_W-1:0]  out_level_r;
  logic [PHASE_W-1:0] out_phase_r;

  // working values
  logic [DATA_W-1:0]     ent_delay, ent_arg, fade_diff;
  logic [DATA_W:0]       sub_wide;
  logic [DATA_W-1:0]     sub_lvl;
  logic signed [DATA_W:0] sub_cmp, sus_cmp;
  logic [DATA_W-1:0]     ticks_dec;
  logic [FINE_W-1:0]     fine_sum;
  logic [DIVIDEND_W-1:0] div_dvd, div_quo;
  logic [DIVISOR_W-1:0]  div_dvs;
  logic                  div_done;
  ent_kind_t             ent_kind;
  logic [GOTO_PW-1:0]    goto_prod;
  logic [DATA_W-1:0]     goto_q_r;
  logic [DATA_W-1:0]     goto_rem0;
  logic [PW-1:0]         goto_slot;

  // slot number of each entry index, folded into the table depth
  for (genvar gi = 0; gi < INDEX_RANGE; gi++) begin : g_idx
    assign idx_tab[gi] = PW'(gi % ENV_DEPTH);
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r   <= in_req_type;
      idx_r   <= in_entry_index;
      delay_r <= in_entry_delay;
      arg_r   <= in_entry_arg;
      bits_r  <= in_action_bits;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_r <= '0;
      sustain_r <= '0;
      step_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_INITIAL: initial_r <= cfg_data;
        REG_SUSTAIN: sustain_r <= cfg_data;
        REG_STEP:    step_r    <= cfg_data;
        default:     ;
      endcase
    end
  end

  // table write and registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[idx_tab[idx_r]] <= {delay_r, arg_r};
    end
    if (cmd.mem_rd) begin
      rd_data_r <= mem[ptr_r];
    end
  end

  // entry decode
  always_comb begin
    ent_delay = rd_data_r[2*DATA_W-1:DATA_W];
    ent_arg   = rd_data_r[DATA_W-1:0];
    case (ent_delay)
      DLY_DISABLE: ent_kind = EK_DISABLE;
      DLY_HANG:    ent_kind = EK_HANG;
      DLY_GOTO:    ent_kind = EK_GOTO;
      DLY_RESTART: ent_kind = EK_RESTART;
      default:     ent_kind = EK_FADE;
    endcase
  end

  // divider operands: fade slope
  always_comb begin
    fade_diff = ent_arg - level_r;
    div_dvd   = {fade_diff, {(DIVIDEND_W-DATA_W){1'b0}}};
    div_dvs   = ent_delay;
  end

  teg_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .signed_op (1'b1),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo)
  );

  // goto slot: quotient estimate registered, then one correcting subtract
  always_comb begin
    goto_prod = GOTO_PW'(ent_arg) * GOTO_PW'(GOTO_MUL);
    goto_rem0 = ent_arg - goto_q_r * DEPTH_W;
    goto_slot = (goto_rem0 >= DEPTH_W) ? PW'(goto_rem0 - DEPTH_W) : PW'(goto_rem0);
  end

  always_ff @(posedge clk) begin
    if (cmd.div_goto) begin
      goto_q_r <= goto_prod[GOTO_PW-1:GOTO_SH];
    end
  end

  // decay and release step with saturation
  always_comb begin
    sub_wide = {level_r[DATA_W-1], level_r} - {2'b00, step_r};
    if (sub_wide[DATA_W] & ~sub_wide[DATA_W-1]) begin
      sub_lvl = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sub_lvl = sub_wide[DATA_W-1:0];
    end
    sub_cmp   = $signed({sub_lvl[DATA_W-1], sub_lvl});
    sus_cmp   = $signed({2'b00, sustain_r});
    ticks_dec = ticks_r - DATA_W'(1);
    fine_sum  = fine_r + vel_r;
  end

  // state updates
  always_comb begin
    case (cmd.lvl_op)
      LVL_INITIAL: level_nxt = {1'b0, initial_r};
      LVL_STEP:    level_nxt = sub_lvl;
      LVL_SUSTAIN: level_nxt = {1'b0, sustain_r};
      LVL_ZERO:    level_nxt = '0;
      LVL_FADE:    level_nxt = fine_sum[FINE_W-1:FINE_W-DATA_W];
      default:     level_nxt = level_r;
    endcase
    case (cmd.fine_op)
      FINE_LOAD: fine_nxt = {level_r, {(FINE_W-DATA_W){1'b0}}};
      FINE_ADD:  fine_nxt = fine_sum;
      default:   fine_nxt = fine_r;
    endcase
    case (cmd.vel_op)
      VEL_CLEAR: vel_nxt = '0;
      VEL_QUOT:  vel_nxt = div_quo;
      default:   vel_nxt = vel_r;
    endcase
    case (cmd.tck_op)
      TCK_CLEAR:   ticks_nxt = '0;
      TCK_ENTRY:   ticks_nxt = ent_delay;
      TCK_DEC:     ticks_nxt = ticks_dec;
      TCK_SUSTAIN: ticks_nxt = DATA_W'(sustain_r >> SUS_SHIFT);
      default:     ticks_nxt = ticks_r;
    endcase
    case (cmd.ptr_op)
      PTR_ZERO: ptr_nxt = '0;
      PTR_INC:  ptr_nxt = (ptr_r == PTR_LAST) ? '0 : ptr_r + PW'(1);
      PTR_GOTO: ptr_nxt = goto_slot;
      default:  ptr_nxt = ptr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      fine_r  <= '0;
      vel_r   <= '0;
      ticks_r <= '0;
      ptr_r   <= '0;
    end else begin
      level_r <= level_nxt;
      fine_r  <= fine_nxt;
      vel_r   <= vel_nxt;
      ticks_r <= ticks_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_level_r <= level_r;
      out_phase_r <= cmd.phase;
    end
  end

  // status back to the controller
  always_comb begin
    sts.req         = req_t'(req_r);
    sts.action_bits = bits_r;
    sts.ent_kind    = ent_kind;
    sts.div_done    = div_done;
    sts.fade_end    = ticks_dec[DATA_W-1] | (ticks_dec == '0);
    sts.sus_end     = (ticks_dec == '0);
    sts.sustain_nz  = (sustain_r != '0);
    sts.below_sus   = (sub_cmp < sus_cmp);
    sts.below_floor = ($signed(sub_lvl) < RELEASE_FLOOR);
  end

  assign out_level = out_level_r;
  assign out_phase = out_phase_r;

endmodule

@@ rtl/teg_ctrl.sv @@
// ----------------------------------------------------------------------------
// teg_ctrl
// Envelope controller: owns the envelope phase and the pending action flags,
// sequences one request at a time through the datapath and hands the result
// to the output channel.
// ----------------------------------------------------------------------------
module teg_ctrl
  import teg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  teg_sts_t sts,
  output teg_cmd_t cmd
);

  ctl_state_t       state_r, state_nxt;
  phase_t           phase_r, phase_nxt;
  logic [ACT_W-1:0] pending_r, pending_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = ~out_valid_r | ~out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      C_IDLE: begin
        if (in_valid) state_nxt = C_RUN;
      end
      C_RUN: begin
        if (sts.req != REQ_TICK) begin
          state_nxt = C_DONE;
        end else begin
          case (phase_r)
            PH_DISABLED:   state_nxt = C_DONE;
            PH_INITIAL:    state_nxt = pending_r[ACT_HANG] ? C_FLAGS : C_RUN;
            PH_START_LOOP: state_nxt = C_RUN;
            PH_LOOP:       state_nxt = C_DECODE;
            default:       state_nxt = C_FLAGS;
          endcase
        end
      end
      C_DECODE: begin
        case (sts.ent_kind)
          EK_GOTO: state_nxt = C_DIV_GOTO;
          EK_FADE: state_nxt = C_DIV_FADE;
          default: state_nxt = C_FLAGS;
        endcase
      end
      C_DIV_GOTO: state_nxt = C_FLAGS;
      C_DIV_FADE: begin
        if (sts.div_done) state_nxt = C_RUN;
      end
      C_FLAGS: state_nxt = C_DONE;
      C_DONE: begin
        if (out_free) state_nxt = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  // commands, phase and flag updates
  always_comb begin
    cmd           = '0;
    cmd.lvl_op    = LVL_KEEP;
    cmd.tck_op    = TCK_KEEP;
    cmd.ptr_op    = PTR_KEEP;
    cmd.vel_op    = VEL_KEEP;
    cmd.fine_op   = FINE_KEEP;
    cmd.phase     = phase_r;
    cmd.capture   = (state_r == C_IDLE) & in_valid;
    phase_nxt     = phase_r;
    pending_nxt   = pending_r;
    out_valid_nxt = out_valid_r & out_stall;
    case (state_r)
      C_RUN: begin
        case (sts.req)
          REQ_WRITE: cmd.mem_wr = 1'b1;
          REQ_POST:  pending_nxt = pending_r | sts.action_bits;
          REQ_START: begin
            phase_nxt   = PH_INITIAL;
            pending_nxt = '0;
            cmd.vel_op  = VEL_CLEAR;
            cmd.tck_op  = TCK_CLEAR;
          end
          default: begin
            // one step of the phase machine
            case (phase_r)
              PH_INITIAL: begin
                cmd.lvl_op = LVL_INITIAL;
                phase_nxt  = pending_r[ACT_HANG] ? PH_HANG : PH_START_LOOP;
              end
              PH_START_LOOP: begin
                cmd.ptr_op  = PTR_ZERO;
                cmd.fine_op = FINE_LOAD;
                phase_nxt   = PH_LOOP;
              end
              PH_LOOP: cmd.mem_rd = 1'b1;
              PH_FADE: begin
                cmd.fine_op = FINE_ADD;
                cmd.lvl_op  = LVL_FADE;
                cmd.tck_op  = TCK_DEC;
                if (sts.fade_end) phase_nxt = PH_LOOP;
              end
              PH_DECAY, PH_RELEASE: begin
                if (sts.sustain_nz && (phase_r == PH_DECAY)) begin
                  if (sts.below_sus) begin
                    cmd.lvl_op = LVL_SUSTAIN;
                    cmd.tck_op = TCK_SUSTAIN;
                    phase_nxt  = PH_SUSTAIN;
                  end else begin
                    cmd.lvl_op = LVL_STEP;
                  end
                end else if (sts.below_floor) begin
                  cmd.lvl_op = LVL_ZERO;
                  phase_nxt  = PH_DISABLED;
                end else begin
                  cmd.lvl_op = LVL_STEP;
                end
              end
              PH_SUSTAIN: begin
                cmd.tck_op = TCK_DEC;
                if (sts.sus_end) phase_nxt = PH_RELEASE;
              end
              default: ;
            endcase
          end
        endcase
      end
      C_DECODE: begin
        cmd.tck_op = TCK_ENTRY;
        case (sts.ent_kind)
          EK_DISABLE: phase_nxt = PH_DISABLED;
          EK_HANG:    phase_nxt = PH_HANG;
          EK_RESTART: phase_nxt = PH_INITIAL;
          EK_GOTO:    cmd.div_goto = 1'b1;
          EK_FADE:    cmd.div_start = 1'b1;
          default:    ;
        endcase
      end
      C_DIV_GOTO: cmd.ptr_op = PTR_GOTO;
      C_DIV_FADE: begin
        if (sts.div_done) begin
          cmd.vel_op = VEL_QUOT;
          cmd.ptr_op = PTR_INC;
          phase_nxt  = PH_FADE;
        end
      end
      C_FLAGS: begin
        // pending flags taken at the start of the tick, applied at its end
        if (pending_r[ACT_DECAY]) begin
          phase_nxt   = PH_DECAY;
          pending_nxt = pending_r & ~(ACT_W'(1) << ACT_DECAY);
        end
        if (pending_r[ACT_RELEASE]) begin
          phase_nxt   = PH_RELEASE;
          pending_nxt = pending_r & ~((ACT_W'(1) << ACT_RELEASE) | (ACT_W'(1) << ACT_DECAY));
        end
      end
      C_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= C_IDLE;
      phase_r     <= PH_DISABLED;
      pending_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != C_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ rtl/table_driven_envelope_generator.sv @@
// ----------------------------------------------------------------------------
// table_driven_envelope_generator
// Integer envelope generator driven by a loaded table of (delay, level)
// entries, with linear 16.16 fades, decay to sustain, timed sustain and
// release cut-off.
//
//   channel | handshake                | carries
//   --------+--------------------------+----------------------------------------
//   in      | in_valid / in_stall      | req_type, entry_index, delay, arg, bits
//   out     | out_valid / out_stall    | level, phase
//   cfg     | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One request is in flight at a time. A tick that loads a fade entry waits on
// the bit-serial divider (32 steps) that forms the fade slope. The result
// register frees the block for the next transfer in while a result waits.
// rst_n is synchronous; there is no clearing pass.
// ----------------------------------------------------------------------------
module table_driven_envelope_generator
  import teg_pkg::*;
#(
  parameter int ENV_DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [REQ_W-1:0]         in_req_type,
  input  logic [INDEX_W-1:0]       in_entry_index,
  input  logic signed [DATA_W-1:0] in_entry_delay,
  input  logic signed [DATA_W-1:0] in_entry_arg,
  input  logic [ACT_W-1:0]         in_action_bits,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_level,
  output logic [PHASE_W-1:0]       out_phase,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [REG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  teg_cmd_t cmd;
  teg_sts_t sts;

  // the user must write registers only while idle; the block does not enforce it, so a write is always taken
  assign cfg_ready = 1'b1;

  teg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  teg_dp #(
    .ENV_DEPTH (ENV_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_req_type    (in_req_type),
    .in_entry_index (in_entry_index),
    .in_entry_delay (in_entry_delay),
    .in_entry_arg   (in_entry_arg),
    .in_action_bits (in_action_bits),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .sts            (sts),
    .out_level      (out_level),
    .out_phase      (out_phase)
  );

endmodule

@@ rtl/teg_checker.sv @@
// ----------------------------------------------------------------------------
// teg_checker
// Port-level checks for the envelope generator, bound to the top level.
// ----------------------------------------------------------------------------
module teg_checker
  import teg_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DATA_W-1:0] out_level,
  input logic [PHASE_W-1:0]       out_phase
);

  // reset leaves no result pending and the input open
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result pending or input stalled after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_level) && $stable(out_phase))
    else $error("stalled result changed");

  // one request in flight: a transfer in closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transfer taken while a request is in flight");

  // the start-loop phase is passed through within a tick, never reported
  a_no_transient_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_phase != PH_START_LOOP)
    else $error("transient start-loop phase reported");

endmodule

bind table_driven_envelope_generator teg_checker u_teg_checker (.*);

@@ tb/sv/table_driven_envelope_generator_chk.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// table_driven_envelope_generator_chk
// Watches the request, result and register channels of the envelope
// generator. It keeps its own copy of the envelope state, works out the level
// and phase that each request leaves behind, and checks every result against
// the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module table_driven_envelope_generator_chk
  import teg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [REQ_W-1:0]         in_req_type,
  input  logic [INDEX_W-1:0]       in_entry_index,
  input  logic signed [DATA_W-1:0] in_entry_delay,
  input  logic signed [DATA_W-1:0] in_entry_arg,
  input  logic [ACT_W-1:0]         in_action_bits,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [DATA_W-1:0] out_level,
  input  logic [PHASE_W-1:0]       out_phase,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [REG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  output int                       n_errors,
  output int                       n_pending
);

  localparam int LEVEL_MIN   = -32768;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [DATA_W-1:0]  level;
    logic [PHASE_W-1:0] phase;
  } env_result_t;

  // expected level and phase, oldest first
  env_result_t expected_levels[$];

  // register copies
  int init_lvl = 0;
  int sus_lvl  = 0;
  int step_amt = 0;

  // envelope state
  phase_t                   ph       = PH_DISABLED;
  logic [ACT_W-1:0]         flags    = '0;
  logic signed [DATA_W-1:0] lvl      = '0;
  logic [FINE_W-1:0]        lvl_fine = '0;
  logic [FINE_W-1:0]        fade_vel = '0;
  logic [DATA_W-1:0]        ticks    = '0;
  logic [INDEX_W-1:0]       ptr      = '0;
  logic [2*DATA_W-1:0]      slots [INDEX_RANGE];

  int mism = 0;

  // one request applied to the envelope state
  task automatic envelope_step(input req_t req, input logic [INDEX_W-1:0] idx,
                               input logic [DATA_W-1:0] dly,
                               input logic [DATA_W-1:0] arg,
                               input logic [ACT_W-1:0] bits);
    logic [ACT_W-1:0]         act;
    logic [2*DATA_W-1:0]      ent;
    logic [FINE_W-1:0]        sh;
    logic signed [DATA_W-1:0] d;
    logic signed [DATA_W-1:0] tgt;
    longint                   num;
    int                       lv;
    bit                       do_start;
    bit                       do_load;
    bit                       do_fade;
    act      = flags;
    do_start = 1'b0;
    do_load  = 1'b0;
    do_fade  = 1'b0;
    case (req)
      REQ_WRITE: slots[idx] = {dly, arg};
      REQ_POST:  flags = flags | bits;
      REQ_START: begin
        ph       = PH_INITIAL;
        flags    = '0;
        fade_vel = '0;
        ticks    = '0;
      end
      default: if (ph != PH_DISABLED) begin
        case (ph)
          PH_INITIAL: begin
            lvl = DATA_W'(init_lvl);
            if (act[ACT_HANG]) ph = PH_HANG;
            else do_start = 1'b1;
          end
          PH_START_LOOP: do_start = 1'b1;
          PH_LOOP:       do_load = 1'b1;
          PH_FADE:       do_fade = 1'b1;
          PH_DECAY, PH_RELEASE: begin
            lv = int'(lvl) - step_amt;
            if (lv < LEVEL_MIN) lv = LEVEL_MIN;
            // decay floors at sustain, release cuts off near zero
            if (sus_lvl != 0 && ph == PH_DECAY) begin
              if (lv < sus_lvl) begin
                lv    = sus_lvl;
                ticks = DATA_W'(sus_lvl >> SUS_SHIFT);
                ph    = PH_SUSTAIN;
              end
            end else if (lv < int'(RELEASE_FLOOR)) begin
              lv = 0;
              ph = PH_DISABLED;
            end
            lvl = DATA_W'(lv);
          end
          PH_SUSTAIN: begin
            ticks = ticks - 1'b1;
            if (ticks == '0) ph = PH_RELEASE;
          end
          default: ;
        endcase
        // restart the table walk from slot zero
        if (do_start) begin
          ptr      = '0;
          lvl_fine = {lvl, 16'h0000};
          ph       = PH_LOOP;
          do_load  = 1'b1;
        end
        // fetch and decode one table entry
        if (do_load) begin
          ent   = slots[ptr];
          d     = ent[2*DATA_W-1:DATA_W];
          ticks = ent[2*DATA_W-1:DATA_W];
          if (d == DLY_DISABLE) ph = PH_DISABLED;
          else if (d == DLY_HANG) ph = PH_HANG;
          else if (d == DLY_GOTO) ptr = INDEX_W'(ent[DATA_W-1:0] % INDEX_RANGE);
          else if (d == DLY_RESTART) ph = PH_INITIAL;
          else begin
            tgt      = ent[DATA_W-1:0];
            sh       = FINE_W'(int'(tgt) - int'(lvl)) << 16;
            num      = longint'($signed(sh));
            fade_vel = FINE_W'(num / longint'(d));
            ph       = PH_FADE;
            ptr      = ptr + 1'b1;
            do_fade  = 1'b1;
          end
        end
        // linear fade in 16.16
        if (do_fade) begin
          lvl_fine = lvl_fine + fade_vel;
          lvl      = lvl_fine[FINE_W-1:DATA_W];
          ticks    = ticks - 1'b1;
          if ($signed(ticks) <= 0) ph = PH_LOOP;
        end
        // pending flags take effect at the end of the tick
        if (act[ACT_DECAY]) begin
          ph    = PH_DECAY;
          flags = act & ~(ACT_W'(1) << ACT_DECAY);
        end
        if (act[ACT_RELEASE]) begin
          ph    = PH_RELEASE;
          flags = act & ~((ACT_W'(1) << ACT_RELEASE) | (ACT_W'(1) << ACT_DECAY));
        end
      end
    endcase
  endtask

  // channel monitor
  always @(posedge clk) begin
    env_result_t got;
    env_result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_INITIAL: init_lvl = int'(cfg_data);
          REG_SUSTAIN: sus_lvl = int'(cfg_data);
          REG_STEP:    step_amt = int'(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        envelope_step(req_t'(in_req_type), in_entry_index, in_entry_delay, in_entry_arg,
                      in_action_bits);
        expected_levels.push_back('{lvl, ph});
      end
      if (out_valid && !out_stall) begin
        got = '{out_level, out_phase};
        if (expected_levels.size() == 0) begin
          mism++;
          if (mism <= MAX_REPORTS)
            $display("%0t: result with nothing expected: level %0d phase %0d", $time,
                     $signed(got.level), got.phase);
        end else begin
          want = expected_levels.pop_front();
          if (got.level !== want.level || got.phase !== want.phase) begin
            mism++;
            if (mism <= MAX_REPORTS)
              $display("%0t: result mismatch: level exp %0d got %0d, phase exp %0d got %0d",
                       $time, $signed(want.level), $signed(got.level), want.phase,
                       got.phase);
          end
        end
      end
    end
    n_errors  <= mism;
    n_pending <= expected_levels.size();
  end

endmodule

@@ tb/sv/table_driven_envelope_generator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// table_driven_envelope_generator_tb
// Drives the envelope generator with a short directed run over the table
// sentinels, fades and action flags, then random notes (table writes, a
// start, ticks with flag posts) mixed with random requests, over several
// register settings and idle patterns. The checker alongside judges results.
// ----------------------------------------------------------------------------
module table_driven_envelope_generator_tb;
  import teg_pkg::*;

  localparam int PHASE_ITEMS = 230;
  localparam int HOLD_AT     = 800;
  localparam int HOLD_LEN    = 400;
  localparam int END_WAIT    = 60;

  logic                     clk            = 1'b0;
  logic                     rst_n          = 1'b0;
  logic                     in_valid       = 1'b0;
  logic                     in_stall;
  logic [REQ_W-1:0]         in_req_type    = '0;
  logic [INDEX_W-1:0]       in_entry_index = '0;
  logic signed [DATA_W-1:0] in_entry_delay = '0;
  logic signed [DATA_W-1:0] in_entry_arg   = '0;
  logic [ACT_W-1:0]         in_action_bits = '0;
  logic                     out_valid;
  logic                     out_stall      = 1'b0;
  logic signed [DATA_W-1:0] out_level;
  logic [PHASE_W-1:0]       out_phase;
  logic                     cfg_valid      = 1'b0;
  logic                     cfg_ready;
  logic [REG_IDX_W-1:0]     cfg_index      = '0;
  logic [CFG_W-1:0]         cfg_data       = '0;

  int   n_errors;
  int   n_pending;
  int   snd_idle  = 0;
  int   rcv_idle  = 0;
  int   n_sent    = 0;
  int   n_in      = 0;
  int   hold_left = 0;
  logic held      = 1'b0;
  int   goal;

  // opening table: one-tick fade to the floor, negative-delay fade to the top,
  // goto with a wide slot number, hang, restart and disable entries
  logic [2*DATA_W-1:0] boot_tbl [INDEX_RANGE] = '{
    {16'h0001, 16'h8000}, {16'h8000, 16'h7FFF}, {DLY_GOTO, 16'h8005},
    {16'h7FFF, 16'h0000}, {DLY_RESTART, 16'h1234}, {DLY_HANG, 16'h7FFF},
    {DLY_DISABLE, 16'h0000}, {16'h0003, 16'h4000}, {16'h0002, 16'hC000},
    {16'hFFFC, 16'h0100}, {16'h0005, 16'h7FFF}, {DLY_GOTO, 16'h0000},
    {16'h0001, 16'h0000}, {DLY_HANG, 16'h0000}, {16'h0004, 16'h8000},
    {DLY_DISABLE, 16'hFFFF}
  };

  table_driven_envelope_generator i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_entry_index (in_entry_index),
    .in_entry_delay (in_entry_delay),
    .in_entry_arg   (in_entry_arg),
    .in_action_bits (in_action_bits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_level      (out_level),
    .out_phase      (out_phase),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  table_driven_envelope_generator_chk i_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_entry_index (in_entry_index),
    .in_entry_delay (in_entry_delay),
    .in_entry_arg   (in_entry_arg),
    .in_action_bits (in_action_bits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_level      (out_level),
    .out_phase      (out_phase),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .n_errors       (n_errors),
    .n_pending      (n_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stall, plus one long hold-off that fills the block
  always @(posedge clk) begin
    if (in_valid && !in_stall) n_in <= n_in + 1;
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!held && n_in >= HOLD_AT) begin
      held      <= 1'b1;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  // offer one request and wait for its transfer
  task automatic send(req_t req, logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] dly,
                      logic [DATA_W-1:0] arg, logic [ACT_W-1:0] bits);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_entry_index <= idx;
    in_entry_delay <= dly;
    in_entry_arg   <= arg;
    in_action_bits <= bits;
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  task automatic send_tick();
    send(REQ_TICK, INDEX_W'($urandom), DATA_W'($urandom), DATA_W'($urandom),
         ACT_W'($urandom));
  endtask

  task automatic send_post();
    send(REQ_POST, INDEX_W'($urandom), DATA_W'($urandom), DATA_W'($urandom),
         ACT_W'($urandom_range(7, 1)));
  endtask

  // table write weighted towards short fades, with sentinels and long fades
  task automatic write_entry();
    logic [DATA_W-1:0]  dly;
    logic [DATA_W-1:0]  arg;
    logic [INDEX_W-1:0] idx;
    int                 k;
    k   = $urandom_range(99);
    arg = DATA_W'($urandom);
    idx = $urandom_range(1) ? INDEX_W'($urandom_range(3)) : INDEX_W'($urandom);
    if (k < 45) dly = DATA_W'($urandom_range(8, 1));
    else if (k < 55) dly = DATA_W'($urandom_range(40, 9));
    else if (k < 62) dly = DATA_W'(32'd0 - $urandom_range(32768, 4));
    else if (k < 64) dly = DATA_W'($urandom_range(32767, 41));
    else if (k < 72) dly = DLY_GOTO;
    else if (k < 80) dly = DLY_HANG;
    else if (k < 88) dly = DLY_RESTART;
    else dly = DLY_DISABLE;
    send(REQ_WRITE, idx, dly, arg, ACT_W'($urandom));
  endtask

  // a few table edits, a start note, then ticks with the odd flag post
  task automatic play_note();
    int n_ticks;
    int k;
    repeat ($urandom_range(4)) write_entry();
    send(REQ_START, INDEX_W'($urandom), DATA_W'($urandom), DATA_W'($urandom),
         ACT_W'($urandom));
    if ($urandom_range(4) == 0) send_post();
    n_ticks = $urandom_range(30, 4);
    repeat (n_ticks) begin
      k = $urandom_range(99);
      if (k < 10) send_post();
      else if (k < 13) write_entry();
      else send_tick();
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  task automatic set_regs(int init_v, int sus_v, int step_v);
    cfg_reg_t         regs [3];
    logic [CFG_W-1:0] vals [3];
    regs = '{REG_INITIAL, REG_SUSTAIN, REG_STEP};
    vals = '{CFG_W'(init_v), CFG_W'(sus_v), CFG_W'(step_v)};
    for (int r = 0; r < 3; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[r];
      cfg_data  <= vals[r];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < 6; p++) begin
      if (p != 0) drain();
      // receiver idles first, then the sender, then neither
      snd_idle = (p < 2) ? 14 : (p < 4) ? 64 : 0;
      rcv_idle <= (p < 2) ? 64 : (p < 4) ? 14 : 0;
      case (p)
        0: set_regs(32767, 0, 32767);
        1: set_regs(0, 32767, 0);
        2: set_regs($urandom_range(32767), $urandom_range(400, 16),
                    $urandom_range(4000, 200));
        3: set_regs($urandom_range(32767), $urandom_range(15, 1), $urandom_range(32767));
        4: set_regs($urandom_range(32767), $urandom_range(32767), $urandom_range(32767));
        default: set_regs($urandom_range(32767), $urandom_range(200, 16),
                          $urandom_range(800, 50));
      endcase
      if (p == 0) begin
        // flags stay pending across a tick while disabled
        send(REQ_POST, '0, '0, '0, ACT_W'(1) << ACT_DECAY);
        send_tick();
        for (int i = 0; i < INDEX_RANGE; i++)
          send(REQ_WRITE, INDEX_W'(i), boot_tbl[i][2*DATA_W-1:DATA_W],
               boot_tbl[i][DATA_W-1:0], '0);
        send(REQ_START, '1, '1, '1, '1);
        // initial with the one-tick fade, then the long negative-delay fade
        repeat (4) send_tick();
        send(REQ_POST, '0, '0, '0, (ACT_W'(1) << ACT_RELEASE) | (ACT_W'(1) << ACT_HANG));
        repeat (2) send_tick();
        send(REQ_START, '0, '0, '0, '0);
      end
      goal = n_sent + PHASE_ITEMS;
      while (n_sent < goal) begin
        if ($urandom_range(9) != 0) begin
          play_note();
        end else begin
          repeat ($urandom_range(3, 1))
            send(req_t'($urandom_range(3)), INDEX_W'($urandom), DATA_W'($urandom),
                 DATA_W'($urandom), ACT_W'($urandom));
        end
      end
    end
    drain();
    repeat (END_WAIT) @(posedge clk);
    if (n_errors == 0 && n_pending == 0) begin
      $display("table_driven_envelope_generator_tb OK");
    end else begin
      $display("table_driven_envelope_generator_tb NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("table_driven_envelope_generator_tb NOT OK");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/teg_pkg.sv
rtl/teg_div.sv
rtl/teg_dp.sv
rtl/teg_ctrl.sv
rtl/table_driven_envelope_generator.sv
rtl/teg_checker.sv
tb/sv/table_driven_envelope_generator_chk.sv
tb/sv/table_driven_envelope_generator_tb.sv
